### rtl/spc_pkg.sv
// Shared types, codes and constants of the paged serial-flash controller.
package spc_pkg;

    localparam int PAGE_COUNT = 2048;
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int OFF_W      = 19;
    localparam int LEN_W      = 20;
    localparam int ADDR_W     = 24;
    localparam int CHUNK_W    = PAGE_BITS + 1;
    localparam int PAGE_SHIFT = 9;
    localparam int FLASH_BYTES = PAGE_COUNT * PAGE_BYTES;

    localparam logic [7:0] OP_PAGE_READ = 8'hD2;
    localparam logic [7:0] OP_STATUS    = 8'hD7;
    localparam logic [7:0] OP_LOAD_BUF  = 8'h53;
    localparam logic [7:0] OP_WRITE_BUF = 8'h84;
    localparam logic [7:0] OP_COMPARE   = 8'h60;
    localparam logic [7:0] OP_PROGRAM   = 8'h83;
    localparam logic [7:0] OP_SLEEP     = 8'hB9;
    localparam logic [7:0] OP_WAKE      = 8'hAB;
    localparam int BIT_READY = 7;
    localparam int BIT_DIFF  = 6;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_FLASH = 3'd3,
        CMD_HOST  = 3'd4,
        CMD_POWER = 3'd5,
        CMD_SYNC  = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        A_SEL       = 3'd0,
        A_SEND      = 3'd1,
        A_RECV      = 3'd2,
        A_DESEL     = 3'd3,
        A_HOST_DATA = 3'd4,
        A_HOST_WANT = 3'd5,
        A_DONE      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        RC_OK     = 2'd0,
        RC_PARAM  = 2'd1,
        RC_NOTRDY = 2'd2,
        RC_BUSY   = 2'd3
    } t_rcode;

    localparam logic [7:0] PWR_OFF = 8'd0;
    localparam logic [7:0] PWR_ON  = 8'd1;
    localparam logic [7:0] PWR_GET = 8'd2;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_POLL_PAGE     = 4'd1,
        PH_READ_BYTES    = 4'd2,
        PH_POLL_LOADED   = 4'd3,
        PH_WRITE_BYTES   = 4'd4,
        PH_POLL_WRITTEN  = 4'd5,
        PH_POLL_COMPARED = 4'd6,
        PH_CMP_STATUS    = 4'd7,
        PH_POLL_SYNC     = 4'd8
    } t_phase;

    // Result slots of one descriptor, emitted lowest first.
    localparam int SLOTS  = 18;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam logic [SLOT_IW-1:0] SL_DATA   = 5'd0;
    localparam logic [SLOT_IW-1:0] SL_DESEL  = 5'd1;
    localparam logic [SLOT_IW-1:0] SL_F_SEL  = 5'd2;
    localparam logic [SLOT_IW-1:0] SL_F_OP   = 5'd3;
    localparam logic [SLOT_IW-1:0] SL_ADDR2  = 5'd4;
    localparam logic [SLOT_IW-1:0] SL_ADDR1  = 5'd5;
    localparam logic [SLOT_IW-1:0] SL_ADDR0  = 5'd6;
    localparam logic [SLOT_IW-1:0] SL_DUM0   = 5'd7;
    localparam logic [SLOT_IW-1:0] SL_DUM1   = 5'd8;
    localparam logic [SLOT_IW-1:0] SL_DUM2   = 5'd9;
    localparam logic [SLOT_IW-1:0] SL_DUM3   = 5'd10;
    localparam logic [SLOT_IW-1:0] SL_F_TAIL = 5'd11;
    localparam logic [SLOT_IW-1:0] SL_P_SEL  = 5'd12;
    localparam logic [SLOT_IW-1:0] SL_P_OP   = 5'd13;
    localparam logic [SLOT_IW-1:0] SL_P_RECV = 5'd14;
    localparam logic [SLOT_IW-1:0] SL_RECV   = 5'd15;
    localparam logic [SLOT_IW-1:0] SL_WANT   = 5'd16;
    localparam logic [SLOT_IW-1:0] SL_DONE   = 5'd17;

    localparam logic [SLOTS-1:0] M_DATA  = SLOTS'(1) << SL_DATA;
    localparam logic [SLOTS-1:0] M_DESEL = SLOTS'(1) << SL_DESEL;
    localparam logic [SLOTS-1:0] M_FRAME = (SLOTS'(1) << SL_F_SEL) | (SLOTS'(1) << SL_F_OP)
                                         | (SLOTS'(1) << SL_F_TAIL);
    localparam logic [SLOTS-1:0] M_ADDR  = (SLOTS'(1) << SL_ADDR2) | (SLOTS'(1) << SL_ADDR1)
                                         | (SLOTS'(1) << SL_ADDR0);
    localparam logic [SLOTS-1:0] M_DUMMY = (SLOTS'(1) << SL_DUM0) | (SLOTS'(1) << SL_DUM1)
                                         | (SLOTS'(1) << SL_DUM2) | (SLOTS'(1) << SL_DUM3);
    localparam logic [SLOTS-1:0] M_POLL  = (SLOTS'(1) << SL_P_SEL) | (SLOTS'(1) << SL_P_OP)
                                         | (SLOTS'(1) << SL_P_RECV);
    localparam logic [SLOTS-1:0] M_RECV  = SLOTS'(1) << SL_RECV;
    localparam logic [SLOTS-1:0] M_WANT  = SLOTS'(1) << SL_WANT;
    localparam logic [SLOTS-1:0] M_DONE  = SLOTS'(1) << SL_DONE;

    // One input's worth of results, as classified by the front end.
    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        logic              data_send;  // data slot: send to flash, else host data
        logic [7:0]        data;
        logic [7:0]        op;
        logic [ADDR_W-1:0] addr;
        logic              tail_recv;  // frame ends in receive slot, else deselect
        t_rcode            code;
        logic              pwr;
    } t_desc;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_qin;

    typedef struct packed {
        logic  empty;
        logic  full;
        t_desc head;
    } t_qout;

endpackage

### rtl/spc_front.sv
// Front end: accepts items, tracks request state, builds result descriptors.
module spc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_command,
    input  logic [spc_pkg::OFF_W-1:0] i_offset,
    input  logic [spc_pkg::LEN_W-1:0] i_length,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_q_full,
    output spc_pkg::t_qin            o_q
);

    logic                         r_init, n_init;
    spc_pkg::t_phase              r_phase, n_phase;
    logic [spc_pkg::OFF_W-1:0]    r_cur_off, n_cur_off;
    logic [spc_pkg::LEN_W-1:0]    r_total, n_total;
    logic [spc_pkg::CHUNK_W-1:0]  r_page_left, n_page_left;
    logic                         r_wmode, n_wmode;

    logic [spc_pkg::CHUNK_W-1:0]  room, chunk, pl_dec;
    logic [spc_pkg::OFF_W-1:0]    fin_off;
    logic [spc_pkg::LEN_W-1:0]    fin_left;
    logic [spc_pkg::ADDR_W-1:0]   page_addr;
    logic [spc_pkg::PAGE_BITS-1:0] in_page;
    logic [spc_pkg::LEN_W:0]      req_end;
    logic                         accept, is_request, poll_phase;
    spc_pkg::t_desc               d;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign in_page   = r_cur_off[spc_pkg::PAGE_BITS-1:0];
    assign room      = spc_pkg::CHUNK_W'(spc_pkg::PAGE_BYTES) - {1'b0, in_page};
    assign chunk     = ({{(spc_pkg::LEN_W-spc_pkg::CHUNK_W){1'b0}}, room} < r_total)
                     ? room : r_total[spc_pkg::CHUNK_W-1:0];
    assign fin_off   = r_cur_off + spc_pkg::OFF_W'(chunk);
    assign fin_left  = r_total - spc_pkg::LEN_W'(chunk);
    assign page_addr = spc_pkg::ADDR_W'(r_cur_off[spc_pkg::OFF_W-1:spc_pkg::PAGE_BITS])
                       << spc_pkg::PAGE_SHIFT;
    assign pl_dec    = (r_page_left != '0) ? r_page_left - 1'b1 : r_page_left;
    assign req_end   = {2'b00, i_offset} + {1'b0, i_length};

    assign is_request = i_command inside {spc_pkg::CMD_INIT, spc_pkg::CMD_READ,
                                          spc_pkg::CMD_WRITE, spc_pkg::CMD_POWER,
                                          spc_pkg::CMD_SYNC};
    assign poll_phase = r_phase inside {spc_pkg::PH_POLL_PAGE, spc_pkg::PH_POLL_LOADED,
                                        spc_pkg::PH_POLL_WRITTEN, spc_pkg::PH_POLL_COMPARED,
                                        spc_pkg::PH_POLL_SYNC};

    always_comb begin
        n_init      = r_init;
        n_phase     = r_phase;
        n_cur_off   = r_cur_off;
        n_total     = r_total;
        n_page_left = r_page_left;
        n_wmode     = r_wmode;
        d           = '0;
        d.code      = spc_pkg::RC_OK;
        d.data      = i_data_byte;
        if (accept) begin
            if (is_request && r_phase != spc_pkg::PH_IDLE) begin
                d.mask = spc_pkg::M_DONE;
                d.code = spc_pkg::RC_BUSY;
            end else begin
                case (i_command)
                    spc_pkg::CMD_INIT: begin
                        d.mask = spc_pkg::M_FRAME | spc_pkg::M_DONE;
                        d.op   = spc_pkg::OP_WAKE;
                        n_init = 1'b1;
                    end
                    spc_pkg::CMD_READ, spc_pkg::CMD_WRITE: begin
                        if (i_length == '0) begin
                            d.mask = spc_pkg::M_DONE;
                            d.code = spc_pkg::RC_PARAM;
                        end else if (!r_init) begin
                            d.mask = spc_pkg::M_DONE;
                            d.code = spc_pkg::RC_NOTRDY;
                        end else if (req_end > (spc_pkg::LEN_W+1)'(spc_pkg::FLASH_BYTES)) begin
                            d.mask = spc_pkg::M_DONE;
                            d.code = spc_pkg::RC_PARAM;
                        end else begin
                            n_cur_off = i_offset;
                            n_total   = i_length;
                            n_wmode   = (i_command == spc_pkg::CMD_WRITE);
                            d.mask    = spc_pkg::M_POLL;
                            n_phase   = spc_pkg::PH_POLL_PAGE;
                        end
                    end
                    spc_pkg::CMD_FLASH: begin
                        if (poll_phase) begin
                            if (!i_data_byte[spc_pkg::BIT_READY]) begin
                                d.mask = spc_pkg::M_RECV;
                            end else begin
                                case (r_phase)
                                    spc_pkg::PH_POLL_PAGE: begin
                                        n_page_left = chunk;
                                        if (!r_wmode) begin
                                            d.mask = spc_pkg::M_DESEL | spc_pkg::M_FRAME
                                                   | spc_pkg::M_ADDR | spc_pkg::M_DUMMY;
                                            d.op   = spc_pkg::OP_PAGE_READ;
                                            d.addr = page_addr
                                                   | spc_pkg::ADDR_W'(in_page);
                                            d.tail_recv = 1'b1;
                                            n_phase = spc_pkg::PH_READ_BYTES;
                                        end else begin
                                            d.mask = spc_pkg::M_DESEL | spc_pkg::M_FRAME
                                                   | spc_pkg::M_ADDR | spc_pkg::M_POLL;
                                            d.op   = spc_pkg::OP_LOAD_BUF;
                                            d.addr = page_addr;
                                            n_phase = spc_pkg::PH_POLL_LOADED;
                                        end
                                    end
                                    spc_pkg::PH_POLL_LOADED: begin
                                        // frame without tail, then ask the host
                                        d.mask = (spc_pkg::M_DESEL | spc_pkg::M_FRAME
                                               | spc_pkg::M_ADDR | spc_pkg::M_WANT)
                                               & ~(spc_pkg::SLOTS'(1) << spc_pkg::SL_F_TAIL);
                                        d.op   = spc_pkg::OP_WRITE_BUF;
                                        d.addr = spc_pkg::ADDR_W'(in_page);
                                        n_phase = spc_pkg::PH_WRITE_BYTES;
                                    end
                                    spc_pkg::PH_POLL_WRITTEN: begin
                                        d.mask = spc_pkg::M_DESEL | spc_pkg::M_FRAME
                                               | spc_pkg::M_ADDR | spc_pkg::M_POLL;
                                        d.op   = spc_pkg::OP_COMPARE;
                                        d.addr = page_addr;
                                        n_phase = spc_pkg::PH_POLL_COMPARED;
                                    end
                                    spc_pkg::PH_POLL_COMPARED: begin
                                        d.mask  = spc_pkg::M_DESEL | spc_pkg::M_POLL;
                                        n_phase = spc_pkg::PH_CMP_STATUS;
                                    end
                                    default: begin
                                        d.mask  = spc_pkg::M_DESEL | spc_pkg::M_DONE;
                                        n_phase = spc_pkg::PH_IDLE;
                                    end
                                endcase
                            end
                        end else if (r_phase == spc_pkg::PH_READ_BYTES) begin
                            n_page_left = pl_dec;
                            if (pl_dec == '0) begin
                                n_cur_off = fin_off;
                                n_total   = fin_left;
                                if (fin_left == '0) begin
                                    d.mask  = spc_pkg::M_DATA | spc_pkg::M_DESEL
                                            | spc_pkg::M_DONE;
                                    n_phase = spc_pkg::PH_IDLE;
                                    n_wmode = 1'b0;
                                end else begin
                                    d.mask  = spc_pkg::M_DATA | spc_pkg::M_DESEL
                                            | spc_pkg::M_POLL;
                                    n_phase = spc_pkg::PH_POLL_PAGE;
                                end
                            end else begin
                                d.mask = spc_pkg::M_DATA | spc_pkg::M_RECV;
                            end
                        end else if (r_phase == spc_pkg::PH_CMP_STATUS) begin
                            d.mask = spc_pkg::M_DESEL;
                            if (i_data_byte[spc_pkg::BIT_DIFF]) begin
                                d.mask = d.mask | spc_pkg::M_FRAME | spc_pkg::M_ADDR;
                                d.op   = spc_pkg::OP_PROGRAM;
                                d.addr = page_addr;
                            end
                            n_cur_off = fin_off;
                            n_total   = fin_left;
                            if (fin_left == '0) begin
                                d.mask  = d.mask | spc_pkg::M_DONE;
                                n_phase = spc_pkg::PH_IDLE;
                                n_wmode = 1'b0;
                            end else begin
                                d.mask  = d.mask | spc_pkg::M_POLL;
                                n_phase = spc_pkg::PH_POLL_PAGE;
                            end
                        end
                    end
                    spc_pkg::CMD_HOST: begin
                        if (r_phase == spc_pkg::PH_WRITE_BYTES) begin
                            d.data_send = 1'b1;
                            n_page_left = pl_dec;
                            if (pl_dec == '0) begin
                                d.mask  = spc_pkg::M_DATA | spc_pkg::M_DESEL
                                        | spc_pkg::M_POLL;
                                n_phase = spc_pkg::PH_POLL_WRITTEN;
                            end else begin
                                d.mask = spc_pkg::M_DATA | spc_pkg::M_WANT;
                            end
                        end
                    end
                    spc_pkg::CMD_POWER: begin
                        if (i_data_byte inside {spc_pkg::PWR_OFF, spc_pkg::PWR_ON}) begin
                            d.mask = spc_pkg::M_FRAME | spc_pkg::M_DONE;
                            d.op   = (i_data_byte == spc_pkg::PWR_OFF)
                                   ? spc_pkg::OP_SLEEP : spc_pkg::OP_WAKE;
                        end else if (i_data_byte == spc_pkg::PWR_GET) begin
                            d.mask = spc_pkg::M_DONE;
                            d.pwr  = 1'b1;
                        end else begin
                            d.mask = spc_pkg::M_DONE;
                            d.code = spc_pkg::RC_PARAM;
                        end
                    end
                    spc_pkg::CMD_SYNC: begin
                        if (!r_init) begin
                            d.mask = spc_pkg::M_DONE;
                            d.code = spc_pkg::RC_NOTRDY;
                        end else begin
                            d.mask  = spc_pkg::M_POLL;
                            n_phase = spc_pkg::PH_POLL_SYNC;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_q.push = accept && (d.mask != '0);
    assign o_q.desc = d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_phase     <= spc_pkg::PH_IDLE;
            r_cur_off   <= '0;
            r_total     <= '0;
            r_page_left <= '0;
            r_wmode     <= 1'b0;
        end else begin
            r_init      <= n_init;
            r_phase     <= n_phase;
            r_cur_off   <= n_cur_off;
            r_total     <= n_total;
            r_page_left <= n_page_left;
            r_wmode     <= n_wmode;
        end
    end

endmodule

### rtl/spc_queue.sv
// Descriptor queue between front end and back end.
module spc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spc_pkg::t_qin  i_q,
    input  logic           i_pop,
    output spc_pkg::t_qout o_q
);

    spc_pkg::t_desc            r_mem [spc_pkg::Q_DEPTH];
    logic [spc_pkg::Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [spc_pkg::Q_AW:0]    r_count;
    logic                      do_push, do_pop;

    assign o_q.empty = (r_count == '0);
    assign o_q.full  = (r_count == (spc_pkg::Q_AW+1)'(spc_pkg::Q_DEPTH));
    assign o_q.head  = r_mem[r_rd_ptr];
    assign do_push   = i_q.push && !o_q.full;
    assign do_pop    = i_pop && !o_q.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (spc_pkg::Q_AW+1)'(do_push) - (spc_pkg::Q_AW+1)'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q.push |-> !o_q.full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_q.empty) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (spc_pkg::Q_AW+1)'(spc_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

### rtl/spc_back.sv
// Back end: expands descriptors into result transfers, one per cycle unless i_ready stalls the output.
module spc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spc_pkg::t_qout i_q,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_action,
    output logic [7:0]     o_spi_or_data_byte,
    output logic [1:0]     o_result_code,
    output logic           o_power_state,
    output logic           o_last
);

    logic [spc_pkg::SLOTS-1:0]   r_mask, cur_mask, rem;
    spc_pkg::t_desc              r_desc, cur;
    logic                        r_valid;
    logic [2:0]                  r_action;
    logic [7:0]                  r_byte;
    logic [1:0]                  r_code;
    logic                        r_pwr, r_last;
    logic [spc_pkg::SLOT_IW-1:0] sl;
    logic                        active, advance, emit;
    spc_pkg::t_action            act;
    logic [7:0]                  byt;

    assign active   = (r_mask != '0);
    assign cur      = active ? r_desc : i_q.head;
    assign cur_mask = active ? r_mask : i_q.head.mask;
    assign advance  = !r_valid || i_ready;
    assign emit     = advance && (active || !i_q.empty);
    assign o_pop    = emit && !active;

    always_comb begin
        sl = '0;
        for (int k = spc_pkg::SLOTS - 1; k >= 0; k--) begin
            if (cur_mask[k]) sl = spc_pkg::SLOT_IW'(k);
        end
    end

    assign rem = cur_mask & ~(spc_pkg::SLOTS'(1) << sl);

    always_comb begin
        byt = 8'h00;
        case (sl)
            spc_pkg::SL_DATA: begin
                act = cur.data_send ? spc_pkg::A_SEND : spc_pkg::A_HOST_DATA;
                byt = cur.data;
            end
            spc_pkg::SL_DESEL:  act = spc_pkg::A_DESEL;
            spc_pkg::SL_F_SEL,
            spc_pkg::SL_P_SEL:  act = spc_pkg::A_SEL;
            spc_pkg::SL_F_OP: begin
                act = spc_pkg::A_SEND;
                byt = cur.op;
            end
            spc_pkg::SL_ADDR2: begin
                act = spc_pkg::A_SEND;
                byt = cur.addr[23:16];
            end
            spc_pkg::SL_ADDR1: begin
                act = spc_pkg::A_SEND;
                byt = cur.addr[15:8];
            end
            spc_pkg::SL_ADDR0: begin
                act = spc_pkg::A_SEND;
                byt = cur.addr[7:0];
            end
            spc_pkg::SL_DUM0, spc_pkg::SL_DUM1,
            spc_pkg::SL_DUM2, spc_pkg::SL_DUM3: act = spc_pkg::A_SEND;
            spc_pkg::SL_F_TAIL: act = cur.tail_recv ? spc_pkg::A_RECV : spc_pkg::A_DESEL;
            spc_pkg::SL_P_OP: begin
                act = spc_pkg::A_SEND;
                byt = spc_pkg::OP_STATUS;
            end
            spc_pkg::SL_P_RECV,
            spc_pkg::SL_RECV:   act = spc_pkg::A_RECV;
            spc_pkg::SL_WANT:   act = spc_pkg::A_HOST_WANT;
            default:            act = spc_pkg::A_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_action <= act;
            r_byte   <= byt;
            r_code   <= (act == spc_pkg::A_DONE) ? cur.code : spc_pkg::RC_OK;
            r_pwr    <= (act == spc_pkg::A_DONE) ? cur.pwr : 1'b0;
            r_last   <= (rem == '0);
            if (!active) r_desc <= i_q.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mask  <= '0;
        end else begin
            if (advance) r_valid <= emit;
            if (emit)    r_mask  <= rem;
        end
    end

    assign o_valid            = r_valid;
    assign o_action           = r_action;
    assign o_spi_or_data_byte = r_byte;
    assign o_result_code      = r_code;
    assign o_power_state      = r_pwr;
    assign o_last             = r_last;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == spc_pkg::A_DONE) |-> o_last) else $error("done not last");
    a_code_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_code != spc_pkg::RC_OK) |-> o_action == spc_pkg::A_DONE)
        else $error("result code on non-done transfer");
    a_pwr_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_power_state) |-> (o_action == spc_pkg::A_DONE && o_last))
        else $error("power state on wrong transfer");
    a_mask_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_mask != '0)) else $error("sequence lost its slots");

endmodule

### rtl/spi_dataflash_page_controller.sv
// Top level of the paged serial-flash page read/write controller.
// Throughput: one input transfer per cycle while the 4-deep descriptor queue
//   has room; results leave at one transfer per cycle while the output is not
//   stalled (up to 11 per input), set by the single back-end slot sequencer and its output register.
// Reset: synchronous active-low i_rst_n clears phase, init flag, queue and
//   output valid; no clearing pass.
module spi_dataflash_page_controller (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input item channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_command,
    input  logic [spc_pkg::OFF_W-1:0] i_offset,
    input  logic [spc_pkg::LEN_W-1:0] i_length,
    input  logic [7:0]                i_data_byte,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_action,
    output logic [7:0]                o_spi_or_data_byte,
    output logic [1:0]                o_result_code,
    output logic                      o_power_state,
    output logic                      o_last
);

    // Front end classifies each input transfer in its accept cycle and keeps
    // the whole request state (phase, offsets, counts), so it never waits on
    // the SPI side. Each input that causes results becomes one descriptor.
    spc_pkg::t_qin  q_in;
    spc_pkg::t_qout q_out;
    logic           q_pop;

    spc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_offset    (i_offset),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_out.full),
        .o_q         (q_in)
    );

    // Short queue decouples the two sides: the front end keeps accepting
    // while the back end is still draining a long command frame.
    spc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_in),
        .i_pop   (q_pop),
        .o_q     (q_out)
    );

    // Back end walks the slot mask of each descriptor lowest slot first,
    // emitting one result per cycle into a registered output stage unless i_ready
    // stalls it; last is flagged on the final slot of the descriptor.
    spc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q                (q_out),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_action           (o_action),
        .o_spi_or_data_byte (o_spi_or_data_byte),
        .o_result_code      (o_result_code),
        .o_power_state      (o_power_state),
        .o_last             (o_last)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the paged serial-flash page controller.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RESET_CYCLES    = 7;
    localparam int unsigned RANDOM_ITEMS    = 420;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int          TAIL_CYCLES     = 50;
    localparam int unsigned MAX_REPORTS     = 30;
    localparam int unsigned MAX_STEP_FRAMES = 16;

    // Command code the block does not define; it must be dropped silently.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [7:0] DUMMY_BYTE = 8'h00;
    localparam logic [7:0] STAT_READY = 8'(1 << BIT_READY);
    localparam logic [7:0] STAT_DIFF  = 8'(1 << BIT_DIFF);

    // One result transfer as the block should present it.
    typedef struct {
        t_action    action;
        logic [7:0] value;
        t_rcode     code;
        logic       pwr;
        logic       last;
    } t_frame;

    // Tracks the controller's sequencing and holds the frames still owed.
    class t_frame_scoreboard;
        bit          initialized;
        t_phase      phase;
        int unsigned cur_off;
        int unsigned total_left;
        int unsigned page_left;
        bit          write_mode;
        t_frame      step_frames[$];
        t_frame      frames_due[$];
        int unsigned step_results;
        int unsigned errors;

        function new();
            initialized  = 1'b0;
            phase        = PH_IDLE;
            cur_off      = 0;
            total_left   = 0;
            page_left    = 0;
            write_mode   = 1'b0;
            step_results = 0;
            errors       = 0;
        endfunction

        function int unsigned pending();
            return frames_due.size();
        endfunction

        function void push_frame(t_action act, logic [7:0] value, t_rcode code, logic pwr);
            t_frame f;
            if (step_frames.size() >= MAX_STEP_FRAMES) return;
            f.action = act;
            f.value  = value;
            f.code   = code;
            f.pwr    = pwr;
            f.last   = 1'b0;
            step_frames.push_back(f);
        endfunction

        function void send_op(logic [7:0] b);
            push_frame(A_SEND, b, RC_OK, 1'b0);
        endfunction

        function void send_addr(logic [ADDR_W-1:0] a);
            send_op(a[23:16]);
            send_op(a[15:8]);
            send_op(a[7:0]);
        endfunction

        function void push_done(t_rcode code);
            push_frame(A_DONE, 8'h00, code, 1'b0);
        endfunction

        // select, status opcode, receive slot; then wait in the given poll phase
        function void poll_start(t_phase next);
            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
            send_op(OP_STATUS);
            push_frame(A_RECV, 8'h00, RC_OK, 1'b0);
            phase = next;
        endfunction

        function int unsigned chunk_size();
            int unsigned room;
            room = PAGE_BYTES - cur_off % PAGE_BYTES;
            return (room < total_left) ? room : total_left;
        endfunction

        function logic [ADDR_W-1:0] page_addr();
            return ADDR_W'((cur_off / PAGE_BYTES) << PAGE_SHIFT);
        endfunction

        // close the page chunk; next page or done
        function void finish_chunk();
            int unsigned c;
            c = chunk_size();
            cur_off    += c;
            total_left -= c;
            if (total_left == 0) begin
                phase      = PH_IDLE;
                write_mode = 1'b0;
                push_done(RC_OK);
            end else begin
                poll_start(PH_POLL_PAGE);
            end
        endfunction

        function void start_request(int unsigned off, int unsigned len, bit wr);
            if (len == 0) begin
                push_done(RC_PARAM);
            end else if (!initialized) begin
                push_done(RC_NOTRDY);
            end else if (off + len > FLASH_BYTES) begin
                push_done(RC_PARAM);
            end else begin
                cur_off    = off;
                total_left = len;
                write_mode = wr;
                poll_start(PH_POLL_PAGE);
            end
        endfunction

        // Called for every input transfer; queues the frames it causes.
        function void note_request(logic [2:0] cmd, logic [OFF_W-1:0] off,
                                   logic [LEN_W-1:0] len, logic [7:0] data);
            logic [ADDR_W-1:0] pa;
            bit                is_req;
            step_frames.delete();
            is_req = cmd inside {CMD_INIT, CMD_READ, CMD_WRITE, CMD_POWER, CMD_SYNC};
            if (is_req && phase != PH_IDLE) begin
                push_done(RC_BUSY);
            end else begin
                case (cmd)
                    CMD_INIT: begin
                        push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                        send_op(OP_WAKE);
                        push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                        initialized = 1'b1;
                        push_done(RC_OK);
                    end
                    CMD_READ:  start_request(off, len, 1'b0);
                    CMD_WRITE: start_request(off, len, 1'b1);
                    CMD_FLASH: begin
                        case (phase)
                            PH_POLL_PAGE, PH_POLL_LOADED, PH_POLL_WRITTEN,
                            PH_POLL_COMPARED, PH_POLL_SYNC: begin
                                if (data[BIT_READY]) begin
                                    pa = page_addr();
                                    push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                    case (phase)
                                        PH_POLL_PAGE: begin
                                            page_left = chunk_size();
                                            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                                            if (!write_mode) begin
                                                send_op(OP_PAGE_READ);
                                                send_addr(pa | ADDR_W'(cur_off % PAGE_BYTES));
                                                repeat (4) send_op(DUMMY_BYTE);
                                                push_frame(A_RECV, 8'h00, RC_OK, 1'b0);
                                                phase = PH_READ_BYTES;
                                            end else begin
                                                send_op(OP_LOAD_BUF);
                                                send_addr(pa);
                                                push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                                poll_start(PH_POLL_LOADED);
                                            end
                                        end
                                        PH_POLL_LOADED: begin
                                            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                                            send_op(OP_WRITE_BUF);
                                            send_addr(ADDR_W'(cur_off % PAGE_BYTES));
                                            push_frame(A_HOST_WANT, 8'h00, RC_OK, 1'b0);
                                            phase = PH_WRITE_BYTES;
                                        end
                                        PH_POLL_WRITTEN: begin
                                            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                                            send_op(OP_COMPARE);
                                            send_addr(pa);
                                            push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                            poll_start(PH_POLL_COMPARED);
                                        end
                                        PH_POLL_COMPARED: begin
                                            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                                            send_op(OP_STATUS);
                                            push_frame(A_RECV, 8'h00, RC_OK, 1'b0);
                                            phase = PH_CMP_STATUS;
                                        end
                                        default: begin  // sync poll
                                            phase = PH_IDLE;
                                            push_done(RC_OK);
                                        end
                                    endcase
                                end else begin
                                    push_frame(A_RECV, 8'h00, RC_OK, 1'b0);
                                end
                            end
                            PH_READ_BYTES: begin
                                push_frame(A_HOST_DATA, data, RC_OK, 1'b0);
                                if (page_left > 0) page_left--;
                                if (page_left == 0) begin
                                    push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                    finish_chunk();
                                end else begin
                                    push_frame(A_RECV, 8'h00, RC_OK, 1'b0);
                                end
                            end
                            PH_CMP_STATUS: begin
                                push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                // program only when the buffer differs from the page
                                if (data[BIT_DIFF]) begin
                                    push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                                    send_op(OP_PROGRAM);
                                    send_addr(page_addr());
                                    push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                end
                                finish_chunk();
                            end
                            default: ;  // stray flash byte
                        endcase
                    end
                    CMD_HOST: begin
                        if (phase == PH_WRITE_BYTES) begin
                            send_op(data);
                            if (page_left > 0) page_left--;
                            if (page_left == 0) begin
                                push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                                poll_start(PH_POLL_WRITTEN);
                            end else begin
                                push_frame(A_HOST_WANT, 8'h00, RC_OK, 1'b0);
                            end
                        end
                    end
                    CMD_POWER: begin
                        if (data inside {PWR_OFF, PWR_ON}) begin
                            push_frame(A_SEL, 8'h00, RC_OK, 1'b0);
                            send_op((data == PWR_OFF) ? OP_SLEEP : OP_WAKE);
                            push_frame(A_DESEL, 8'h00, RC_OK, 1'b0);
                            push_done(RC_OK);
                        end else if (data == PWR_GET) begin
                            push_frame(A_DONE, 8'h00, RC_OK, 1'b1);
                        end else begin
                            push_done(RC_PARAM);
                        end
                    end
                    CMD_SYNC: begin
                        if (!initialized) push_done(RC_NOTRDY);
                        else poll_start(PH_POLL_SYNC);
                    end
                    default: ;  // undefined command
                endcase
            end
            step_results = step_frames.size();
            if (step_results != 0) step_frames[step_results - 1].last = 1'b1;
            foreach (step_frames[i]) frames_due.push_back(step_frames[i]);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_transfer(logic [2:0] act, logic [7:0] value, logic [1:0] code,
                                     logic pwr, logic last);
            t_frame f;
            if (frames_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result transfer with none expected, actual action %0d",
                             $time, act);
                return;
            end
            f = frames_due.pop_front();
            if (act !== f.action)  report("action", f.action, act);
            if (value !== f.value) report("spi_or_data_byte", f.value, value);
            if (code !== f.code)   report("result_code", f.code, code);
            if (pwr !== f.pwr)     report("power_state", f.pwr, pwr);
            if (last !== f.last)   report("last", f.last, last);
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [2:0]           i_command   = '0;
    logic [OFF_W-1:0]     i_offset    = '0;
    logic [LEN_W-1:0]     i_length    = '0;
    logic [7:0]           i_data_byte = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [2:0]           o_action;
    logic [7:0]           o_spi_or_data_byte;
    logic [1:0]           o_result_code;
    logic                 o_power_state;
    logic                 o_last;

    t_frame_scoreboard sb = new();

    int unsigned cycle_cnt = 0;
    int unsigned tx_burst  = 0;
    int unsigned rx_left   = 0;

    spi_dataflash_page_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_offset           (i_offset),
        .i_length           (i_length),
        .i_data_byte        (i_data_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_action           (o_action),
        .o_spi_or_data_byte (o_spi_or_data_byte),
        .o_result_code      (o_result_code),
        .o_power_state      (o_power_state),
        .o_last             (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop in case a transfer never completes.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result-side stalls: short ones mostly, some long, some stall-free stretches.
    always @(posedge i_clk) begin : rx_stall
        int unsigned roll;
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                i_ready <= 1'b1;
                rx_left <= $urandom_range(0, 4);
            end else if (roll < 63) begin
                i_ready <= 1'b1;
                rx_left <= $urandom_range(20, 80);
            end else if (roll < 93) begin
                i_ready <= 1'b0;
                rx_left <= $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b0;
                rx_left <= $urandom_range(8, 20);
            end
        end
    end

    // Every result transfer is checked against the oldest owed frame.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_transfer(o_action, o_spi_or_data_byte, o_result_code, o_power_state, o_last);
    end

    // Gap before the next input transfer; occasionally a run of back-to-back items.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (tx_burst != 0) begin
            tx_burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            tx_burst = $urandom_range(15, 50);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Valid byte range; mostly short, often touching a page end.
    function automatic void pick_range(output logic [OFF_W-1:0] off,
                                       output logic [LEN_W-1:0] len);
        int unsigned roll;
        int unsigned span;
        int unsigned start;
        roll = $urandom_range(0, 99);
        if (roll < 70)      span = $urandom_range(1, 6);
        else if (roll < 98) span = $urandom_range(7, 24);
        else                span = $urandom_range(PAGE_BYTES - 8, PAGE_BYTES + 40);
        start = $urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES;
        if ($urandom_range(0, 1)) start += PAGE_BYTES - $urandom_range(1, 8);
        else                      start += $urandom_range(0, PAGE_BYTES - 1);
        if (start + span > FLASH_BYTES) start = FLASH_BYTES - span;
        off = OFF_W'(start);
        len = LEN_W'(span);
    endfunction

    // Zero length or a range past the end of the flash.
    function automatic void pick_bad_range(output logic [OFF_W-1:0] off,
                                           output logic [LEN_W-1:0] len);
        int unsigned o;
        case ($urandom_range(0, 2))
            0: begin
                off = OFF_W'($urandom);
                len = '0;
            end
            1: begin
                o   = $urandom_range(1, FLASH_BYTES - 1);
                off = OFF_W'(o);
                len = LEN_W'(FLASH_BYTES - o + $urandom_range(1, 4096));
            end
            default: begin
                off = OFF_W'($urandom);
                len = LEN_W'($urandom_range(FLASH_BYTES + 1, (1 << LEN_W) - 1));
            end
        endcase
    endfunction

    // Present one item and hold it until the transfer happens.
    task automatic send_item(logic [2:0] cmd, logic [OFF_W-1:0] off,
                             logic [LEN_W-1:0] len, logic [7:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_offset    <= off;
        i_length    <= len;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(cmd, off, len, data);
    endtask

    // Hold off the input side until every owed frame has come out.
    task automatic wait_frames_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        // before init
        send_item(CMD_READ, 19'd0, 20'd5, 8'h00);
        send_item(CMD_SYNC, '0, '0, 8'h00);
        send_item(CMD_WRITE, 19'd100, 20'd0, 8'h00);      // zero length ranks first
        send_item(CMD_POWER, '0, '0, PWR_GET);
        send_item(CMD_POWER, '0, '0, PWR_OFF);
        send_item(CMD_POWER, '0, '0, PWR_ON);
        send_item(CMD_POWER, '0, '0, 8'hFF);               // unknown subcode
        send_item(CMD_UNUSED, '1, '1, 8'hFF);              // dropped
        send_item(CMD_FLASH, '0, '0, 8'hFF);               // stray flash byte
        send_item(CMD_HOST, '0, '0, 8'h00);                // stray host byte
        send_item(CMD_INIT, '0, '0, 8'h00);
        send_item(CMD_READ, 19'd1, LEN_W'(FLASH_BYTES), 8'h00);  // one past the end
        send_item(CMD_WRITE, '0, '1, 8'h00);
        // last byte of the flash: one not-ready status, a busy request, then data
        send_item(CMD_READ, '1, 20'd1, 8'h00);
        send_item(CMD_FLASH, '0, '0, 8'h00);
        send_item(CMD_SYNC, '0, '0, 8'h00);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
        send_item(CMD_FLASH, '0, '0, 8'h5A);
        // one-byte write whose compare reports a difference
        send_item(CMD_WRITE, '0, 20'd1, 8'h00);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
        send_item(CMD_HOST, '0, '0, 8'hFF);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
        send_item(CMD_FLASH, '0, '0, STAT_READY | STAT_DIFF);
        send_item(CMD_SYNC, '0, '0, 8'h00);
        send_item(CMD_FLASH, '0, '0, STAT_READY);
    endtask

    // Mostly complete request sequences with random content, some noise.
    // Once the item budget is spent the open sequence is finished cleanly.
    task automatic run_random(int unsigned n_items);
        int unsigned      counted;
        int unsigned      roll;
        bit               winding;
        bit               drained;
        logic [2:0]       cmd;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        counted = 0;
        drained = 1'b0;
        while (counted < n_items || sb.phase != PH_IDLE) begin
            winding = (counted >= n_items);
            if (!drained && counted >= n_items / 2) begin
                wait_frames_drained();
                drained = 1'b1;
            end
            roll = $urandom_range(0, 99);
            off  = OFF_W'($urandom);
            len  = LEN_W'($urandom);
            data = 8'($urandom);
            if (sb.phase == PH_IDLE) begin
                if (roll < 35) begin
                    cmd = CMD_READ;
                    pick_range(off, len);
                end else if (roll < 70) begin
                    cmd = CMD_WRITE;
                    pick_range(off, len);
                end else if (roll < 75) begin
                    cmd = CMD_SYNC;
                end else if (roll < 80) begin
                    cmd = CMD_POWER;
                    case ($urandom_range(0, 3))
                        0:       data = PWR_OFF;
                        1:       data = PWR_ON;
                        2:       data = PWR_GET;
                        default: data = 8'($urandom_range(3, 255));
                    endcase
                end else if (roll < 83) begin
                    cmd = CMD_INIT;
                end else if (roll < 91) begin
                    cmd = roll[0] ? CMD_READ : CMD_WRITE;
                    pick_bad_range(off, len);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_UNUSED;
                        1:       cmd = CMD_FLASH;
                        default: cmd = CMD_HOST;
                    endcase
                end
            end else if (!winding && roll < 10) begin
                if (roll < 6) begin
                    // request while a sequence runs
                    case ($urandom_range(0, 4))
                        0:       cmd = CMD_INIT;
                        1:       cmd = CMD_READ;
                        2:       cmd = CMD_WRITE;
                        3:       cmd = CMD_POWER;
                        default: cmd = CMD_SYNC;
                    endcase
                end else if (roll < 8) begin
                    cmd = CMD_UNUSED;
                end else begin
                    // byte from the side that is not being waited on
                    cmd = (sb.phase == PH_WRITE_BYTES) ? CMD_FLASH : CMD_HOST;
                end
            end else begin
                case (sb.phase)
                    PH_WRITE_BYTES: cmd = CMD_HOST;
                    PH_READ_BYTES, PH_CMP_STATUS: cmd = CMD_FLASH;
                    default: begin
                        // status poll: ready most of the time
                        cmd = CMD_FLASH;
                        data[BIT_READY] = winding || ($urandom_range(0, 99) < 80);
                    end
                endcase
            end
            send_item(cmd, off, len, data);
            if (sb.step_results != 0) counted++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_frames_drained();
        run_random(RANDOM_ITEMS);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/spc_pkg.sv
rtl/spc_front.sv
rtl/spc_queue.sv
rtl/spc_back.sv
rtl/spi_dataflash_page_controller.sv
tb/tb_top.sv
